[rtl/mwf_pkg.sv]
// Shared types, codes and defaults for the marker watershed flood block.
package mwf_pkg;

  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_MAX_COLS   = 64;
  localparam int DEF_VALUE_BITS = 16;
  localparam int DEF_LABEL_BITS = 16;

  localparam int CFG_BITS = 7;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_FLOOD = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_OUT,
    ST_SEED_RD,
    ST_SEED_CHK,
    ST_POP,
    ST_NB_RD,
    ST_NB_CHK
  } state_t;

  // Command broadcast to every cell of the queue.
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } qcmd_t;

endpackage

[rtl/mwf_cell.sv]
// One cell of the sorted queue: holds one word, inserts or shifts with its neighbors.
module mwf_cell #(
  parameter int EW = 8,
  parameter int KW = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  mwf_pkg::qcmd_t cmd,
  input  logic [EW-1:0]  push_word,
  input  logic [EW-1:0]  prev_word,
  input  logic           prev_valid,
  input  logic           prev_ins,
  input  logic [EW-1:0]  next_word,
  input  logic           next_valid,
  output logic [EW-1:0]  word,
  output logic           valid,
  output logic           ins
);
  import mwf_pkg::*;

  // The new word belongs at or before this cell.
  assign ins = !valid || (push_word[EW-1 -: KW] < word[EW-1 -: KW]);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      valid <= 1'b0;
    end else if (cmd.pop) begin
      word  <= next_word;
      valid <= next_valid;
    end else if (cmd.push && ins) begin
      if (!prev_ins) begin
        word  <= push_word;
        valid <= 1'b1;
      end else begin
        word  <= prev_word;
        valid <= prev_valid;
      end
    end
  end

endmodule

[rtl/mwf_chain.sv]
// Row of queue cells kept sorted by key; the head cell holds the minimum.
module mwf_chain #(
  parameter int N  = 4,
  parameter int EW = 8,
  parameter int KW = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  mwf_pkg::qcmd_t cmd,
  input  logic [EW-1:0]  push_word,
  output logic [EW-1:0]  head_word,
  output logic           head_valid
);
  import mwf_pkg::*;

  logic [EW-1:0] words [N];
  logic          vals  [N];
  logic          inss  [N];

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [EW-1:0] pw, nw;
    logic          pv, pi, nv;
    if (g == 0) begin : g_first
      assign pw = '0;
      assign pv = 1'b0;
      assign pi = 1'b0;
    end else begin : g_mid
      assign pw = words[g-1];
      assign pv = vals[g-1];
      assign pi = inss[g-1];
    end
    if (g == N-1) begin : g_last
      assign nw = '0;
      assign nv = 1'b0;
    end else begin : g_nxt
      assign nw = words[g+1];
      assign nv = vals[g+1];
    end
    mwf_cell #(.EW(EW), .KW(KW)) u_cell (
      .clk(clk), .rst(rst), .cmd(cmd), .push_word(push_word),
      .prev_word(pw), .prev_valid(pv), .prev_ins(pi),
      .next_word(nw), .next_valid(nv),
      .word(words[g]), .valid(vals[g]), .ins(inss[g])
    );
  end

  assign head_word  = words[0];
  assign head_valid = vals[0];

endmodule

[rtl/marker_watershed_priority_flood_top.sv]
// Top level of the marker watershed flood: pixel stores, flood sequencer, queue.
//
//  channel | signals                                      | dir
//  in      | in_valid, in_stall, op, pixel_index, ...     | in
//  out     | out_valid, out_stall, label, flood_done      | out
//  cfg     | cfg_we, cfg_index, cfg_data                  | in
//
// A load writes the stores on acceptance; a read takes a registered store read, then the
// output word. A flood seeds each pixel (seed read, then seed check), then per popped pixel
// reads each neighbor and checks those inside the image: bound by the single store read port.
// Reset is synchronous; rows and cols return to 64, the queue empties.
// in_stall is high while a flood or read is at work or while an output word waits.
module marker_watershed_priority_flood_top #(
  parameter int MAX_ROWS   = mwf_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS   = mwf_pkg::DEF_MAX_COLS,
  parameter int VALUE_BITS = mwf_pkg::DEF_VALUE_BITS,
  parameter int LABEL_BITS = mwf_pkg::DEF_LABEL_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   op,
  input  logic [11:0]                  pixel_index,
  input  logic signed [15:0]           pixel_value,
  input  logic [15:0]                  marker_label,
  input  logic                         in_mask,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [15:0]                  label,
  output logic                         flood_done,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [mwf_pkg::CFG_BITS-1:0] cfg_data
);
  import mwf_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int IW    = ((AW > 12) ? AW : 12) + 1;
  localparam int KW    = VALUE_BITS + AW;
  localparam int EW    = KW + AW + RW + CW + LABEL_BITS;
  // payload offsets inside a queue word
  localparam int O_LAB = 0;
  localparam int O_COL = O_LAB + LABEL_BITS;
  localparam int O_ROW = O_COL + CW;
  localparam int O_IDX = O_ROW + RW;

  logic [VALUE_BITS-1:0] value_mem [DEPTH];
  logic                  mask_mem  [DEPTH];
  logic [LABEL_BITS-1:0] label_mem [DEPTH];

  logic [CFG_BITS-1:0] rows, cols;
  state_t state, state_next;

  logic [RW-1:0] nr;
  logic [CW-1:0] nc;
  logic [10:0]   rows_w, cols_w;

  logic          in_acc;
  logic [IW-1:0] pidx_w;
  logic          pidx_ok;
  logic [AW-1:0] pidx;

  logic [AW-1:0] seed_idx, age;
  logic [RW-1:0] seed_row;
  logic [CW-1:0] seed_col;
  logic          seed_last;

  logic [AW-1:0]         cur_idx;
  logic [RW-1:0]         cur_row;
  logic [CW-1:0]         cur_col;
  logic [LABEL_BITS-1:0] cur_lab;
  logic [1:0]            k;
  logic                  k_last;

  logic          nb_ok;
  logic [AW-1:0] nb_j, nb_idx;
  logic [RW-1:0] nb_r, nb_row;
  logic [CW-1:0] nb_c, nb_col;

  logic [AW-1:0]         rd_addr;
  logic [VALUE_BITS-1:0] rd_value;
  logic                  rd_mask;
  logic [LABEL_BITS-1:0] rd_label;
  logic                  rd_oob;

  qcmd_t                 qcmd;
  logic [EW-1:0]         push_word, head_word;
  logic                  head_valid;
  logic [AW-1:0]         push_idx;
  logic [RW-1:0]         push_row;
  logic [CW-1:0]         push_col;
  logic [LABEL_BITS-1:0] push_lab;

  logic                  load_we, nb_we, out_set;
  logic [LABEL_BITS-1:0] load_lab;
  logic [LABEL_BITS-1:0] load_mk;
  logic [VALUE_BITS-1:0] load_val;

  // Clamp rows and cols into range.
  assign rows_w = 11'(rows);
  assign cols_w = 11'(cols);
  assign nr = (rows == '0) ? RW'(1) :
              ((rows_w > 11'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows));
  assign nc = (cols == '0) ? CW'(1) :
              ((cols_w > 11'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cols));

  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign pidx_w   = IW'(pixel_index);
  assign pidx_ok  = pidx_w < IW'(DEPTH);
  assign pidx     = AW'(pixel_index);

  assign seed_last = (seed_row == nr - RW'(1)) && (seed_col == nc - CW'(1));
  assign k_last    = (k == DIR_DOWN);

  // Neighbor of the popped pixel in direction k.
  always_comb begin
    nb_ok = 1'b0;
    nb_j  = cur_idx;
    nb_r  = cur_row;
    nb_c  = cur_col;
    unique case (dir_t'(k))
      DIR_UP: begin
        nb_ok = cur_row != '0;
        nb_j  = cur_idx - AW'(nc);
        nb_r  = cur_row - RW'(1);
      end
      DIR_LEFT: begin
        nb_ok = cur_col != '0;
        nb_j  = cur_idx - AW'(1);
        nb_c  = cur_col - CW'(1);
      end
      DIR_RIGHT: begin
        nb_ok = (cur_col + CW'(1)) < nc;
        nb_j  = cur_idx + AW'(1);
        nb_c  = cur_col + CW'(1);
      end
      DIR_DOWN: begin
        nb_ok = (cur_row + RW'(1)) < nr;
        nb_j  = cur_idx + AW'(nc);
        nb_r  = cur_row + RW'(1);
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && op == OP_FLOOD) state_next = ST_SEED_RD;
        else if (in_acc && op == OP_READ) state_next = ST_RD_OUT;
      end
      ST_RD_OUT:   state_next = ST_IDLE;
      ST_SEED_RD:  state_next = ST_SEED_CHK;
      ST_SEED_CHK: state_next = seed_last ? ST_POP : ST_SEED_RD;
      ST_POP:      state_next = head_valid ? ST_NB_RD : ST_IDLE;
      ST_NB_RD: begin
        if (nb_ok) state_next = ST_NB_CHK;
        else if (k_last) state_next = ST_POP;
      end
      ST_NB_CHK:   state_next = k_last ? ST_POP : ST_NB_RD;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    qcmd     = '0;
    rd_addr  = pidx;
    load_we  = 1'b0;
    nb_we    = 1'b0;
    out_set  = 1'b0;
    push_idx = nb_idx;
    push_row = nb_row;
    push_col = nb_col;
    push_lab = cur_lab;
    unique case (state)
      ST_IDLE: begin
        load_we    = in_acc && op == OP_LOAD && pidx_ok;
        qcmd.clear = in_acc && op == OP_FLOOD;
      end
      ST_RD_OUT:  out_set = 1'b1;
      ST_SEED_RD: rd_addr = seed_idx;
      ST_SEED_CHK: begin
        qcmd.push = (rd_label != '0) && rd_mask;
        push_idx  = seed_idx;
        push_row  = seed_row;
        push_col  = seed_col;
        push_lab  = rd_label;
      end
      ST_POP: begin
        qcmd.pop = head_valid;
        out_set  = !head_valid;
      end
      ST_NB_RD: rd_addr = nb_j;
      ST_NB_CHK: begin
        nb_we     = rd_mask && (rd_label == '0);
        qcmd.push = nb_we;
      end
      default: ;
    endcase
  end

  assign push_word = {~rd_value[VALUE_BITS-1], rd_value[VALUE_BITS-2:0], age,
                      push_idx, push_row, push_col, push_lab};

  assign load_val = VALUE_BITS'(pixel_value);
  assign load_mk  = LABEL_BITS'(marker_label);
  assign load_lab = (load_mk != '0 && in_mask) ? load_mk : '0;

  // Pixel stores.
  always_ff @(posedge clk) begin
    if (load_we) begin
      value_mem[pidx] <= load_val;
      mask_mem[pidx]  <= in_mask;
    end
    if (load_we) label_mem[pidx] <= load_lab;
    else if (nb_we) label_mem[nb_idx] <= cur_lab;
    rd_value <= value_mem[rd_addr];
    rd_mask  <= mask_mem[rd_addr];
    rd_label <= label_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rows      <= CFG_RESET;
      cols      <= CFG_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_index == CFG_ROWS) rows <= cfg_data;
      if (cfg_we && cfg_index == CFG_COLS) cols <= cfg_data;
      if (out_set) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_acc) begin
      rd_oob   <= !pidx_ok;
      seed_idx <= '0;
      seed_row <= '0;
      seed_col <= '0;
      age      <= '0;
    end
    if (state == ST_SEED_CHK) begin
      seed_idx <= seed_idx + AW'(1);
      if (seed_col == nc - CW'(1)) begin
        seed_col <= '0;
        seed_row <= seed_row + RW'(1);
      end else begin
        seed_col <= seed_col + CW'(1);
      end
    end
    if (qcmd.push) age <= age + AW'(1);
    if (state == ST_POP) begin
      k       <= DIR_UP;
      cur_idx <= head_word[O_IDX +: AW];
      cur_row <= head_word[O_ROW +: RW];
      cur_col <= head_word[O_COL +: CW];
      cur_lab <= head_word[O_LAB +: LABEL_BITS];
    end
    if (state == ST_NB_RD) begin
      nb_idx <= nb_j;
      nb_row <= nb_r;
      nb_col <= nb_c;
      if (!nb_ok) k <= k + 2'd1;
    end
    if (state == ST_NB_CHK) k <= k + 2'd1;
    if (out_set) begin
      flood_done <= (state == ST_POP);
      label      <= (state == ST_RD_OUT && !rd_oob) ? 16'(rd_label) : '0;
    end
  end

  mwf_chain #(.N(DEPTH), .EW(EW), .KW(KW)) u_chain (
    .clk(clk), .rst(rst), .cmd(qcmd), .push_word(push_word),
    .head_word(head_word), .head_valid(head_valid)
  );

endmodule

[rtl/mwf_checker.sv]
// Port-level checks on the marker watershed flood block, bound to its top level.
module mwf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  op,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] label,
  input logic        flood_done
);
  import mwf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(label) && $stable(flood_done))
    else $error("output word changed while stalled");

  a_done_label: assert property (@(posedge clk) disable iff (rst)
    out_valid && flood_done |-> label == '0)
    else $error("flood word carries a label");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (op == OP_READ || op == OP_FLOOD) |=> in_stall)
    else $error("input taken while read or flood at work");

endmodule

bind marker_watershed_priority_flood_top mwf_checker u_mwf_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .op(op),
  .out_valid(out_valid), .out_stall(out_stall), .label(label),
  .flood_done(flood_done)
);

[tb/marker_watershed_priority_flood_top_tb.sv]
// Testbench for the marker watershed flood: directed tables, random phases, scoreboard.
`timescale 1ns / 100ps

module marker_watershed_priority_flood_top_tb;
  import mwf_pkg::*;

  localparam int STORE_DEPTH = 4096;
  localparam int N_MAX = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_WORDS = 1100;

  typedef struct {
    logic [1:0]         op;
    logic [11:0]        idx;
    logic signed [15:0] val;
    logic [15:0]        mk;
    logic               msk;
    bit                 has_exp;
    logic [15:0]        exp_label;
    logic               exp_done;
  } word_t;

  typedef struct {
    logic [15:0] label;
    logic        done;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] label;
  logic flood_done;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_BITS-1:0] cfg_data = '0;
  word_t cur = '{op: OP_NONE, idx: '0, val: '0, mk: '0, msk: 1'b0,
                 has_exp: 1'b0, exp_label: '0, exp_done: 1'b0};

  always #5 clk = ~clk;

  marker_watershed_priority_flood_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(cur.op), .pixel_index(cur.idx), .pixel_value(cur.val),
    .marker_label(cur.mk), .in_mask(cur.msk),
    .out_valid(out_valid), .out_stall(out_stall),
    .label(label), .flood_done(flood_done),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Mirror of the block's stores and the flood queue.
  int          val_mem [STORE_DEPTH];
  bit          msk_mem [STORE_DEPTH];
  logic [15:0] lab_mem [STORE_DEPTH];
  bit          written [STORE_DEPTH];
  int          hv [STORE_DEPTH];
  int          ha [STORE_DEPTH];
  int          hx [STORE_DEPTH];
  int          heap_n;
  int          age_next;
  int          rows_reg = 64;
  int          cols_reg = 64;

  word_t   words_to_send [$];
  result_t expected_results [$];
  int      mismatches = 0;
  int      n_loads = 0, n_floods = 0, n_reads = 0, n_phases = 0;
  int      words_made = 0;
  bit      long_hold_req = 1'b0;

  function automatic int clamp_dim(int raw);
    if (raw < 1) return 1;
    if (raw > N_MAX) return N_MAX;
    return raw;
  endfunction

  function automatic bit heap_before(int a, int b);
    if (hv[a] != hv[b]) return hv[a] < hv[b];
    return ha[a] < ha[b];
  endfunction

  function automatic void heap_swap(int a, int b);
    int tv, ta, tx;
    tv = hv[a]; ta = ha[a]; tx = hx[a];
    hv[a] = hv[b]; ha[a] = ha[b]; hx[a] = hx[b];
    hv[b] = tv; ha[b] = ta; hx[b] = tx;
  endfunction

  function automatic void q_insert(int pix);
    int i, p;
    if (heap_n >= STORE_DEPTH) return;
    i = heap_n;
    heap_n++;
    hv[i] = val_mem[pix];
    ha[i] = age_next;
    hx[i] = pix;
    age_next++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!heap_before(i, p)) break;
      heap_swap(i, p);
      i = p;
    end
  endfunction

  function automatic int q_take_min();
    int top, i, l, r, m;
    top = hx[0];
    heap_n--;
    hv[0] = hv[heap_n]; ha[0] = ha[heap_n]; hx[0] = hx[heap_n];
    i = 0;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      if (l < heap_n && heap_before(l, m)) m = l;
      if (r < heap_n && heap_before(r, m)) m = r;
      if (m == i) break;
      heap_swap(i, m);
      i = m;
    end
    return top;
  endfunction

  function automatic void flood_labels();
    int nr, nc, e, r, c, rr, cc, j;
    logic [15:0] lab;
    int dr [4] = '{-1, 0, 0, 1};
    int dc [4] = '{0, -1, 1, 0};
    nr = clamp_dim(rows_reg);
    nc = clamp_dim(cols_reg);
    heap_n = 0;
    age_next = 0;
    for (int i = 0; i < nr * nc; i++)
      if (lab_mem[i] != 0 && msk_mem[i]) q_insert(i);
    while (heap_n > 0) begin
      e = q_take_min();
      r = e / nc;
      c = e % nc;
      lab = lab_mem[e];
      for (int k = 0; k < 4; k++) begin
        rr = r + dr[k];
        cc = c + dc[k];
        if (rr < 0 || rr >= nr || cc < 0 || cc >= nc) continue;
        j = rr * nc + cc;
        if (!msk_mem[j] || lab_mem[j] != 0) continue;
        lab_mem[j] = lab;
        q_insert(j);
      end
    end
  endfunction

  // Update the mirror for one accepted word and queue its result, if any.
  function automatic void predict_word(word_t w);
    result_t res;
    case (w.op)
      OP_LOAD: begin
        val_mem[w.idx] = w.val;
        msk_mem[w.idx] = w.msk;
        lab_mem[w.idx] = (w.mk != 0 && w.msk) ? w.mk : 16'd0;
        n_loads++;
      end
      OP_FLOOD: begin
        flood_labels();
        res.label = 16'd0;
        res.done = 1'b1;
        n_floods++;
      end
      OP_READ: begin
        res.label = lab_mem[w.idx];
        res.done = 1'b0;
        n_reads++;
      end
      default: ;
    endcase
    if (w.op == OP_FLOOD || w.op == OP_READ) begin
      if (w.has_exp) begin
        res.label = w.exp_label;
        res.done = w.exp_done;
      end
      expected_results.push_back(res);
    end
  endfunction

  // Sender: bursts of random length with random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_word(cur);
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (words_to_send.size() > 0) begin
        cur <= words_to_send.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern of its own, plus one long hold-off on request.
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  bit long_hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(10, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Scoreboard on the output channel.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output word: label %0h done %0b", label, flood_done);
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (label !== e.label || flood_done !== e.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected label %0h done %0b, got label %0h done %0b",
                     e.label, e.done, label, flood_done);
        end
      end
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    while (words_to_send.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    // a trailing load may still be in the block
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, int data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[CFG_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROWS) rows_reg = data & 7'h7f;
    else cols_reg = data & 7'h7f;
  endtask

  function automatic word_t mk_word(logic [1:0] o, int idx, int v, int mk, bit m);
    word_t w;
    w.op = o; w.idx = 12'(idx); w.val = 16'(v); w.mk = 16'(mk); w.msk = m;
    w.has_exp = 1'b0; w.exp_label = '0; w.exp_done = 1'b0;
    return w;
  endfunction

  function automatic word_t mk_check(logic [1:0] o, int idx, int lab, bit done);
    word_t w;
    w = mk_word(o, idx, 0, 0, 1'b0);
    w.has_exp = 1'b1; w.exp_label = 16'(lab); w.exp_done = done;
    return w;
  endfunction

  function automatic word_t rand_load(int idx, bit wide_vals);
    int v, mk;
    v = wide_vals ? int'($urandom_range(0, 65535)) - 32768 : int'($urandom_range(0, 7)) - 4;
    mk = ($urandom_range(0, 9) < 2) ? $urandom_range(1, 65535) : 0;
    if ($urandom_range(0, 19) == 0) mk = 0;
    written[idx] = 1'b1;
    return mk_word(OP_LOAD, idx, v, mk, $urandom_range(0, 99) < 85);
  endfunction

  function automatic int pick_written();
    int idx;
    do idx = $urandom_range(0, STORE_DEPTH - 1); while (!written[idx]);
    return idx;
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(65, 127);
      2: return 64;
      3: return 1;
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  task automatic random_phase();
    int r, c, n, reads;
    bit wide;
    r = pick_dim();
    c = pick_dim();
    // keep the image small most of the time
    if (clamp_dim(r) * clamp_dim(c) > 64) c = $urandom_range(0, 1);
    write_cfg(CFG_ROWS, r);
    write_cfg(CFG_COLS, c);
    n = clamp_dim(r) * clamp_dim(c);
    wide = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) words_to_send.push_back(rand_load(i, wide));
    for (int i = 0; i < $urandom_range(0, 4); i++)
      words_to_send.push_back(rand_load($urandom_range(0, STORE_DEPTH - 1), 1'b1));
    if ($urandom_range(0, 4) == 0)
      words_to_send.push_back(mk_word(OP_NONE, $urandom, $urandom, $urandom, $urandom));
    words_to_send.push_back(mk_word(OP_FLOOD, $urandom, $urandom, $urandom, $urandom));
    if ($urandom_range(0, 5) == 0)
      words_to_send.push_back(mk_word(OP_FLOOD, 0, 0, 0, 1'b0));
    reads = $urandom_range(4, 16);
    for (int i = 0; i < reads; i++) begin
      words_to_send.push_back(mk_word(OP_READ, ($urandom_range(0, 3) == 0) ?
                              pick_written() : $urandom_range(0, n - 1), 0, 0, 1'b0));
      if ($urandom_range(0, 7) == 0)
        words_to_send.push_back(rand_load($urandom_range(0, STORE_DEPTH - 1), 1'b1));
    end
    words_made += words_to_send.size();
    n_phases++;
  endtask

  initial begin
    word_t table_a [10];
    word_t table_b [7];
    table_a = '{
      mk_word(OP_LOAD, 0, -32768, 16'hffff, 1'b1),
      mk_word(OP_LOAD, 4095, 32767, 16'hffff, 1'b0),
      mk_check(OP_READ, 0, 16'hffff, 1'b0),
      mk_check(OP_READ, 4095, 16'h0000, 1'b0),
      mk_word(OP_LOAD, 1, 16'h5555, 16'haaaa, 1'b1),
      mk_check(OP_READ, 1, 16'haaaa, 1'b0),
      mk_word(OP_LOAD, 2, -1, 16'h5555, 1'b0),
      mk_check(OP_READ, 2, 16'h0000, 1'b0),
      mk_word(OP_NONE, 12'hfff, -1, 16'hffff, 1'b1),
      mk_check(OP_READ, 0, 16'hffff, 1'b0)
    };
    // one row of three: marker floods its masked neighbor, unmasked pixel stays 0
    table_b = '{
      mk_word(OP_LOAD, 0, 5, 16'd9, 1'b1),
      mk_word(OP_LOAD, 1, 0, 16'd0, 1'b1),
      mk_word(OP_LOAD, 2, 0, 16'd4, 1'b0),
      mk_check(OP_FLOOD, 0, 16'd0, 1'b1),
      mk_check(OP_READ, 1, 16'd9, 1'b0),
      mk_check(OP_READ, 2, 16'd0, 1'b0),
      mk_check(OP_FLOOD, 0, 16'd0, 1'b1)
    };
    for (int i = 0; i < STORE_DEPTH; i++) begin
      written[i] = 1'b0;
      lab_mem[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (table_a[i]) begin
      if (table_a[i].op == OP_LOAD) written[table_a[i].idx] = 1'b1;
      words_to_send.push_back(table_a[i]);
    end
    wait_idle();
    write_cfg(CFG_ROWS, 1);
    write_cfg(CFG_COLS, 3);
    foreach (table_b[i]) words_to_send.push_back(table_b[i]);
    wait_idle();

    while (words_made < RANDOM_WORDS) begin
      random_phase();
      if (n_phases == 5) begin
        // long receiver hold while reads pile up behind it
        for (int i = 0; i < 60; i++)
          words_to_send.push_back(mk_word(OP_READ, pick_written(), 0, 0, 1'b0));
        words_made += 60;
        long_hold_req = 1'b1;
      end
      wait_idle();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d phases: %0d loads, %0d floods, %0d reads",
             n_phases, n_loads, n_floods, n_reads);
    $display("dimensions from 1 up to 64 per side, out-of-range settings, %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mwf_pkg.sv
rtl/mwf_cell.sv
rtl/mwf_chain.sv
rtl/marker_watershed_priority_flood_top.sv
rtl/mwf_checker.sv
tb/marker_watershed_priority_flood_top_tb.sv
